// File: src/audio_jitter_buffer_macros.svh
// Assertion helpers for the jitter buffer.
`ifndef AUDIO_JITTER_BUFFER_MACROS_SVH
`define AUDIO_JITTER_BUFFER_MACROS_SVH
// Implication checked each clock, disabled in reset.
`define AJB_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication, disabled in reset.
`define AJB_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// File: src/ajb_pkg.sv
package ajb_pkg;

  localparam int WINDOW_DEPTH = 64;
  localparam int HANDLE_BITS  = 16;
  localparam int MAX_PAYLOAD  = 1024;

  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_PACKET = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_RSVD   = 2'd3;

  localparam logic [3:0] ACT_STORED  = 4'd0;
  localparam logic [3:0] ACT_LATE    = 4'd1;
  localparam logic [3:0] ACT_EMPTY   = 4'd2;
  localparam logic [3:0] ACT_TOOFAR  = 4'd3;
  localparam logic [3:0] ACT_NOTLIVE = 4'd4;
  localparam logic [3:0] ACT_SILENCE = 4'd5;
  localparam logic [3:0] ACT_DECODE  = 4'd6;
  localparam logic [3:0] ACT_CONCEAL = 4'd7;
  localparam logic [3:0] ACT_DISCON  = 4'd8;

  localparam logic [1:0] REG_MAXB = 2'd0;
  localparam logic [1:0] REG_MINB = 2'd1;
  localparam logic [1:0] REG_TICK = 2'd2;
  localparam logic [1:0] REG_TOUT = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] seq_number;
    logic [10:0] payload_length;
    logic [15:0] payload_handle;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  action;
    logic        play_flag;
    logic [31:0] seq_out;
    logic [15:0] handle_out;
    logic [10:0] length_out;
    logic        last;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_PKT, ST_GROW, ST_STORE, ST_TICK, ST_SIL,
    ST_PLAY, ST_PLAYRD, ST_EMIT, ST_WAIT
  } state_t;

endpackage

// File: src/ajb_slot_ram.sv
// Slot descriptor store: one write port, one registered read port.
module ajb_slot_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [26:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [26:0]   rdata
);
  logic [26:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: src/audio_jitter_buffer.sv
// Sequenced jitter buffer. When not live a result is registered straight from idle;
// a dropped packet passes the offset check, a stored one then the grow and store steps.
// Ticks: silence passes the tick step, and the silence step when the window is empty;
// a played slot passes play and read, repeated per skip-ahead slot once a result leaves.
// Throughput: one item at a time; in_stall is high until the last result leaves.
// Reset: synchronous active low; a clearing pass follows reset, start, disconnect.
module audio_jitter_buffer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ajb_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ajb_pkg::out_beat_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  localparam int WINDOW_DEPTH = ajb_pkg::WINDOW_DEPTH;
  localparam int HANDLE_BITS  = ajb_pkg::HANDLE_BITS;
  localparam int MAX_PAYLOAD  = ajb_pkg::MAX_PAYLOAD;
  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [31:0] DEPTH32 = 32'(WINDOW_DEPTH);
  localparam logic [10:0] MAXP11  = (MAX_PAYLOAD > 2047) ? 11'h7ff : 11'(MAX_PAYLOAD);
  localparam logic [15:0] HMASK   = (HANDLE_BITS >= 16) ? 16'hffff :
                                    16'((1 << HANDLE_BITS) - 1);

  // config registers
  logic [6:0]  maxb_r, minb_r;
  logic [9:0]  tick_r;
  logic [15:0] tout_r;
  logic        cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxb_r <= 7'd8; minb_r <= 7'd2; tick_r <= 10'd20; tout_r <= 16'd2000;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'b00) begin
      unique case (cfg_paddr[3:2])
        ajb_pkg::REG_MAXB: maxb_r <= cfg_pwdata[6:0];
        ajb_pkg::REG_MINB: minb_r <= cfg_pwdata[6:0];
        ajb_pkg::REG_TICK: tick_r <= cfg_pwdata[9:0];
        ajb_pkg::REG_TOUT: tout_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      ajb_pkg::REG_MAXB: cfg_prdata = {25'd0, maxb_r};
      ajb_pkg::REG_MINB: cfg_prdata = {25'd0, minb_r};
      ajb_pkg::REG_TICK: cfg_prdata = {22'd0, tick_r};
      ajb_pkg::REG_TOUT: cfg_prdata = {16'd0, tout_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // effective maximum, clamped at 2; values above the depth never match
  logic [7:0] maxb_e;
  assign maxb_e = (maxb_r < 7'd2) ? 8'd2 : {1'b0, maxb_r};

  // state
  ajb_pkg::state_t state_r, state_nxt;
  logic [WINDOW_DEPTH-1:0] pres_r, pres_nxt;
  logic [31:0] front_r, front_nxt, sil_r, sil_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic        incb_r, incb_nxt, live_r, live_nxt;
  logic [7:0]  miss_r, miss_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [6:0]  k_r, k_nxt;
  ajb_pkg::in_beat_t  item_r, item_nxt;
  ajb_pkg::out_beat_t ob_r, ob_nxt;
  logic [31:0] off_r, off_nxt;
  logic        skip;

  // shared adder
  logic [31:0] alu_a, alu_b;
  logic [32:0] alu_s;
  logic        alu_sub;
  assign alu_s = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});

  // slot store
  logic          ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [26:0]   ram_rd;
  ajb_slot_ram #(.DEPTH(WINDOW_DEPTH), .AW(AW)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_wa),
    .wdata({item_r.payload_length, item_r.payload_handle & HMASK}),
    .raddr(ram_ra), .rdata(ram_rd)
  );

  assign in_stall  = (state_r != ajb_pkg::ST_IDLE);
  assign out_valid = (state_r == ajb_pkg::ST_WAIT);
  assign out_data  = ob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ajb_pkg::ST_CLEAR; pres_r <= '0; front_r <= 32'd1; sil_r <= '0;
      head_r <= '0; fill_r <= FW'(1); incb_r <= 1'b1; live_r <= 1'b0;
      miss_r <= '0; cnt_r <= '0; k_r <= '0;
    end else begin
      state_r <= state_nxt; pres_r <= pres_nxt; front_r <= front_nxt; sil_r <= sil_nxt;
      head_r <= head_nxt; fill_r <= fill_nxt; incb_r <= incb_nxt; live_r <= live_nxt;
      miss_r <= miss_nxt; cnt_r <= cnt_nxt; k_r <= k_nxt;
    end
    item_r <= item_nxt; ob_r <= ob_nxt; off_r <= off_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r; pres_nxt = pres_r; front_nxt = front_r; sil_nxt = sil_r;
    head_nxt = head_r; fill_nxt = fill_r; incb_nxt = incb_r; live_nxt = live_r;
    miss_nxt = miss_r; cnt_nxt = cnt_r; k_nxt = k_r; item_nxt = item_r;
    ob_nxt = ob_r; off_nxt = off_r; skip = 1'b0;
    alu_a = front_r; alu_b = 32'd1; alu_sub = 1'b0;
    ram_we = 1'b0; ram_wa = head_r + off_r[AW-1:0]; ram_ra = head_r;
    unique case (state_r)
      ajb_pkg::ST_IDLE: begin
        item_nxt = in_data;
        ob_nxt = '0;
        ob_nxt.last = 1'b1;
        k_nxt = '0;
        if (in_valid) begin
          unique case (in_data.func)
            ajb_pkg::FUNC_START: begin
              front_nxt = 32'd1; head_nxt = '0; fill_nxt = FW'(1); incb_nxt = 1'b1;
              miss_nxt = '0; sil_nxt = '0; live_nxt = 1'b1; cnt_nxt = '0;
              state_nxt = ajb_pkg::ST_CLEAR;
            end
            ajb_pkg::FUNC_PACKET: begin
              ob_nxt.seq_out = in_data.seq_number;
              ob_nxt.action = ajb_pkg::ACT_NOTLIVE;
              state_nxt = live_r ? ajb_pkg::ST_PKT : ajb_pkg::ST_WAIT;
            end
            ajb_pkg::FUNC_TICK: begin
              ob_nxt.seq_out = front_r;
              ob_nxt.action = ajb_pkg::ACT_NOTLIVE;
              state_nxt = live_r ? ajb_pkg::ST_TICK : ajb_pkg::ST_WAIT;
            end
            default: ;
          endcase
        end
      end
      ajb_pkg::ST_CLEAR: begin
        pres_nxt[cnt_r] = 1'b0;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == AW'(WINDOW_DEPTH - 1)) begin
          cnt_nxt = '0;
          state_nxt = ajb_pkg::ST_IDLE;
        end
      end
      ajb_pkg::ST_PKT: begin
        // offset = seq - front
        alu_a = item_r.seq_number; alu_b = front_r; alu_sub = 1'b1;
        off_nxt = alu_s[31:0];
        state_nxt = ajb_pkg::ST_WAIT;
        if (item_r.payload_length == 11'd0 || item_r.payload_length > MAXP11)
          ob_nxt.action = ajb_pkg::ACT_EMPTY;
        else if (alu_s[32]) ob_nxt.action = ajb_pkg::ACT_LATE;
        else if (alu_s[31:0] >= DEPTH32) ob_nxt.action = ajb_pkg::ACT_TOOFAR;
        else state_nxt = ajb_pkg::ST_GROW;
      end
      ajb_pkg::ST_GROW: begin
        // one cleared slot per cycle until fill exceeds offset
        if ({{(32-FW){1'b0}}, fill_r} <= off_r) begin
          pres_nxt[head_r + fill_r[AW-1:0]] = 1'b0;
          fill_nxt = fill_r + FW'(1);
        end else state_nxt = ajb_pkg::ST_STORE;
      end
      ajb_pkg::ST_STORE: begin
        ram_we = 1'b1;
        pres_nxt[head_r + off_r[AW-1:0]] = 1'b1;
        ob_nxt.action = ajb_pkg::ACT_STORED;
        state_nxt = ajb_pkg::ST_WAIT;
      end
      ajb_pkg::ST_TICK: begin
        if (incb_r && {{(8-FW){1'b0}}, fill_r} < maxb_e) begin
          ob_nxt.action = ajb_pkg::ACT_SILENCE;
          if (fill_r == FW'(1) && !pres_r[head_r]) state_nxt = ajb_pkg::ST_SIL;
          else begin
            incb_nxt = 1'b0;
            state_nxt = ajb_pkg::ST_WAIT;
          end
        end else state_nxt = ajb_pkg::ST_PLAY;
      end
      ajb_pkg::ST_SIL: begin
        alu_a = sil_r; alu_b = {22'd0, tick_r};
        sil_nxt = alu_s[32] ? 32'hffff_ffff : alu_s[31:0];
        state_nxt = ajb_pkg::ST_WAIT;
        if (sil_nxt > {16'd0, tout_r}) begin
          ob_nxt.action = ajb_pkg::ACT_DISCON;
          front_nxt = 32'd1; head_nxt = '0; fill_nxt = FW'(1); incb_nxt = 1'b1;
          miss_nxt = '0; sil_nxt = '0; live_nxt = 1'b0; cnt_nxt = '0;
          pres_nxt = '0;
        end
      end
      ajb_pkg::ST_PLAY: begin
        // ram read launched at head
        state_nxt = ajb_pkg::ST_PLAYRD;
      end
      ajb_pkg::ST_PLAYRD: begin
        ob_nxt = '0;
        ob_nxt.seq_out = front_r;
        ob_nxt.play_flag = 1'b1;
        if (pres_r[head_r]) begin
          miss_nxt = '0; sil_nxt = '0;
          ob_nxt.action = ajb_pkg::ACT_DECODE;
          ob_nxt.length_out = ram_rd[26:16];
          ob_nxt.handle_out = ram_rd[15:0];
        end else begin
          if (miss_r != 8'hff) miss_nxt = miss_r + 8'd1;
          if ({1'b0, fill_r} < {1'b0, minb_r} || (miss_nxt > 8'd1 &&
              {{(8-FW){1'b0}}, fill_r} < maxb_e))
            incb_nxt = 1'b1;
          ob_nxt.action = ajb_pkg::ACT_CONCEAL;
        end
        pres_nxt[head_r] = 1'b0;
        front_nxt = alu_s[31:0];
        if (fill_r > FW'(1)) begin
          head_nxt = head_r + AW'(1);
          fill_nxt = fill_r - FW'(1);
        end
        skip = {{(8-FW){1'b0}}, fill_nxt} >= maxb_e;
        if (skip) ob_nxt.play_flag = 1'b0;
        k_nxt = k_r + 7'd1;
        ob_nxt.last = !(skip && (k_nxt < 7'(WINDOW_DEPTH > 127 ? 127 : WINDOW_DEPTH)));
        state_nxt = ajb_pkg::ST_WAIT;
      end
      ajb_pkg::ST_WAIT: begin
        if (!out_stall) begin
          if (ob_r.last) state_nxt = (live_r || ob_r.action != ajb_pkg::ACT_DISCON)
                                     ? ajb_pkg::ST_IDLE : ajb_pkg::ST_CLEAR;
          else state_nxt = ajb_pkg::ST_PLAY;
        end
      end
      default: state_nxt = ajb_pkg::ST_IDLE;
    endcase
  end

  `include "audio_jitter_buffer_macros.svh"
  `AJB_ASSERT_IMP(a_out_only_wait, out_valid, state_r == ajb_pkg::ST_WAIT, "out_valid outside wait")
  `AJB_ASSERT_IMP(a_fill_range, 1'b1, fill_r >= FW'(1) && fill_r <= FW'(WINDOW_DEPTH), "fill out of range")
  `AJB_ASSERT_NXT(a_no_accept_busy, in_valid && !in_stall && in_data.func == ajb_pkg::FUNC_TICK && live_r, in_stall, "tick not held")
endmodule

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = ajb_pkg::WINDOW_DEPTH;
  localparam int MAXPAY     = ajb_pkg::MAX_PAYLOAD;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = 100;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  ajb_pkg::in_beat_t   in_data;
  logic       out_valid;
  logic       out_stall;
  ajb_pkg::out_beat_t  out_data;
  logic       cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  audio_jitter_buffer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted jitter buffer state and registers
  logic        slot_p [DEPTH];
  logic [10:0] slot_len [DEPTH];
  logic [15:0] slot_hdl [DEPTH];
  logic [31:0] front;
  logic [5:0]  head;
  logic [6:0]  fill;
  bit          rebuf, live;
  logic [7:0]  misses;
  logic [31:0] sil;
  logic [6:0]  maxb, minb;
  logic [9:0]  tickms;
  logic [15:0] tout;

  ajb_pkg::out_beat_t playout_q[$];
  int          errors = 0;
  bit          quiet = 0;
  bit          long_hold = 0;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void reset_window();
    foreach (slot_p[i]) slot_p[i] = 1'b0;
    front  = 32'd1;
    head   = '0;
    fill   = 7'd1;
    rebuf  = 1'b1;
    misses = '0;
    sil    = '0;
  endfunction

  // Work out the result beats one input beat causes and queue them
  function automatic void predict_playout(ajb_pkg::in_beat_t b);
    ajb_pkg::out_beat_t r[$];
    ajb_pkg::out_beat_t o;
    logic [31:0] off;
    logic [32:0] t;
    logic [6:0]  mx;
    logic [5:0]  h;
    bit          skip;
    int          k;
    mx = (maxb < 2) ? 7'd2 : maxb;
    o = '0;
    case (b.func)
      ajb_pkg::FUNC_START: begin
        reset_window();
        live = 1'b1;
        return;
      end
      ajb_pkg::FUNC_PACKET: begin
        o.seq_out = b.seq_number;
        if (!live) o.action = ajb_pkg::ACT_NOTLIVE;
        else if (b.payload_length == 0 || b.payload_length > MAXPAY)
          o.action = ajb_pkg::ACT_EMPTY;
        else if (b.seq_number < front) o.action = ajb_pkg::ACT_LATE;
        else begin
          off = b.seq_number - front;
          if (off >= DEPTH) o.action = ajb_pkg::ACT_TOOFAR;
          else begin
            // grow the window with cleared slots
            while (fill <= off) begin
              slot_p[6'(head + fill)] = 1'b0;
              fill++;
            end
            h = 6'(head + off);
            slot_p[h]   = 1'b1;
            slot_len[h] = b.payload_length;
            slot_hdl[h] = b.payload_handle;
            o.action = ajb_pkg::ACT_STORED;
          end
        end
        r.push_back(o);
      end
      ajb_pkg::FUNC_TICK: begin
        o.seq_out = front;
        if (!live) begin
          o.action = ajb_pkg::ACT_NOTLIVE;
          r.push_back(o);
        end else if (rebuf && fill < mx) begin
          o.action = ajb_pkg::ACT_SILENCE;
          if (fill == 1 && !slot_p[head]) begin
            t = {1'b0, sil} + {23'd0, tickms};
            sil = t[32] ? '1 : t[31:0];
            if (sil > {16'd0, tout}) begin
              o.action = ajb_pkg::ACT_DISCON;
              reset_window();
              live = 1'b0;
            end
          end else rebuf = 1'b0;
          r.push_back(o);
        end else begin
          // play front slot; keep going while skipping ahead
          k = 0;
          do begin
            h = head;
            o = '0;
            o.seq_out = front;
            o.play_flag = 1'b1;
            if (slot_p[h]) begin
              misses = '0;
              sil    = '0;
              o.action     = ajb_pkg::ACT_DECODE;
              o.handle_out = slot_hdl[h];
              o.length_out = slot_len[h];
            end else begin
              if (misses < 255) misses++;
              if (fill < minb || (misses > 1 && fill < mx)) rebuf = 1'b1;
              o.action = ajb_pkg::ACT_CONCEAL;
            end
            slot_p[h] = 1'b0;
            front++;
            if (fill > 1) begin
              head = h + 6'd1;
              fill--;
            end
            skip = fill >= mx;
            if (skip) o.play_flag = 1'b0;
            r.push_back(o);
            k++;
          end while (skip && k < DEPTH);
        end
      end
      default: return;
    endcase
    r[$].last = 1'b1;
    foreach (r[i]) playout_q.push_back(r[i]);
  endfunction

  // Offer one beat after a random gap; predict at acceptance
  task automatic send(ajb_pkg::in_beat_t b, bit chk = 0,
                      logic [3:0] act = ajb_pkg::ACT_STORED);
    int gap, base;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    base = playout_q.size();
    predict_playout(b);
    if (chk && playout_q[base].action !== act)
      report("directed action", 32'(playout_q[base].action), 32'(act));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (playout_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      ajb_pkg::REG_MAXB: maxb   = val[6:0];
      ajb_pkg::REG_MINB: minb   = val[6:0];
      ajb_pkg::REG_TICK: tickms = val[9:0];
      default:           tout   = val[15:0];
    endcase
  endtask

  task automatic set_regs(logic [6:0] mxb, logic [6:0] mnb, logic [9:0] tk, logic [15:0] to);
    write_reg(ajb_pkg::REG_MAXB, 32'(mxb));
    write_reg(ajb_pkg::REG_MINB, 32'(mnb));
    write_reg(ajb_pkg::REG_TICK, 32'(tk));
    write_reg(ajb_pkg::REG_TOUT, 32'(to));
  endtask

  function automatic ajb_pkg::in_beat_t mk(logic [1:0] f, logic [31:0] s, logic [10:0] l,
                                           logic [15:0] hd);
    ajb_pkg::in_beat_t b;
    b.func = f;
    b.seq_number = s;
    b.payload_length = l;
    b.payload_handle = hd;
    return b;
  endfunction

  // Random beat: mostly in-window packets and ticks
  task automatic random_beat(output bit counted);
    int r;
    logic [31:0] s;
    r = $urandom_range(0, 99);
    counted = 1'b1;
    if (r < 3) send(mk(ajb_pkg::FUNC_START, $urandom, 11'($urandom), 16'($urandom)));
    else if (r < 48) begin
      s = ($urandom_range(0, 9) == 0) ? 32'(front + $urandom_range(0, DEPTH - 1))
                                      : 32'(front + $urandom_range(0, fill + 2));
      send(mk(ajb_pkg::FUNC_PACKET, s, 11'($urandom_range(1, MAXPAY)), 16'($urandom)));
    end else if (r < 52) begin
      s = (front > 1) ? 32'(front - $urandom_range(1, 3)) : $urandom;
      send(mk(ajb_pkg::FUNC_PACKET, s, 11'($urandom_range(1, MAXPAY)), 16'($urandom)));
    end else if (r < 55) begin
      s = ($urandom_range(0, 1) == 0) ? 32'(front + DEPTH + $urandom_range(0, 1000))
                                      : $urandom;
      send(mk(ajb_pkg::FUNC_PACKET, s, 11'($urandom_range(1, MAXPAY)), 16'($urandom)));
    end else if (r < 58) begin
      send(mk(ajb_pkg::FUNC_PACKET, front, ($urandom_range(0, 1) == 0) ? 11'd0
              : 11'($urandom_range(MAXPAY + 1, 2047)), 16'($urandom)));
    end else if (r < 60) begin
      send(mk(ajb_pkg::FUNC_RSVD, $urandom, 11'($urandom), 16'($urandom)));
      counted = 1'b0;
    end else send(mk(ajb_pkg::FUNC_TICK, $urandom, 11'($urandom), 16'($urandom)));
  endtask

  typedef struct {
    ajb_pkg::in_beat_t beat;
    bit                chk;
    logic [3:0]        act;
  } dir_row_t;

  dir_row_t dir_rows[$] = '{
    '{mk(ajb_pkg::FUNC_TICK,   32'd0,         11'd0,    16'h0000), 1, ajb_pkg::ACT_NOTLIVE},
    '{mk(ajb_pkg::FUNC_PACKET, 32'd5,         11'd10,   16'h1234), 1, ajb_pkg::ACT_NOTLIVE},
    '{mk(ajb_pkg::FUNC_START,  32'd0,         11'd0,    16'h0000), 0, ajb_pkg::ACT_STORED},
    '{mk(ajb_pkg::FUNC_PACKET, 32'd1,         11'd0,    16'h0001), 1, ajb_pkg::ACT_EMPTY},
    '{mk(ajb_pkg::FUNC_PACKET, 32'd1,         11'd1025, 16'h0002), 1, ajb_pkg::ACT_EMPTY},
    '{mk(ajb_pkg::FUNC_PACKET, 32'hFFFF_FFFF, 11'd2047, 16'hFFFF), 1, ajb_pkg::ACT_EMPTY},
    '{mk(ajb_pkg::FUNC_PACKET, 32'd0,         11'd10,   16'h0003), 1, ajb_pkg::ACT_LATE},
    '{mk(ajb_pkg::FUNC_PACKET, 32'd65,        11'd10,   16'h0004), 1, ajb_pkg::ACT_TOOFAR},
    '{mk(ajb_pkg::FUNC_PACKET, 32'hFFFF_FFFF, 11'd10,   16'h0005), 1, ajb_pkg::ACT_TOOFAR},
    '{mk(ajb_pkg::FUNC_PACKET, 32'd1,         11'd1024, 16'hFFFF), 1, ajb_pkg::ACT_STORED},
    '{mk(ajb_pkg::FUNC_PACKET, 32'd1,         11'd1,    16'h0000), 1, ajb_pkg::ACT_STORED},
    '{mk(ajb_pkg::FUNC_RSVD,   32'hFFFF_FFFF, 11'd2047, 16'hFFFF), 0, ajb_pkg::ACT_STORED},
    '{mk(ajb_pkg::FUNC_TICK,   32'd0,         11'd0,    16'h0000), 1, ajb_pkg::ACT_SILENCE},
    '{mk(ajb_pkg::FUNC_TICK,   32'd0,         11'd0,    16'h0000), 1, ajb_pkg::ACT_DECODE},
    '{mk(ajb_pkg::FUNC_TICK,   32'd0,         11'd0,    16'h0000), 1, ajb_pkg::ACT_CONCEAL},
    '{mk(ajb_pkg::FUNC_TICK,   32'd0,         11'd0,    16'h0000), 1, ajb_pkg::ACT_SILENCE},
    '{mk(ajb_pkg::FUNC_PACKET, 32'd4,         11'd7,    16'hA5A5), 1, ajb_pkg::ACT_STORED},
    '{mk(ajb_pkg::FUNC_PACKET, 32'd66,        11'd512,  16'h5A5A), 1, ajb_pkg::ACT_STORED},
    '{mk(ajb_pkg::FUNC_TICK,   32'd0,         11'd0,    16'h0000), 0, ajb_pkg::ACT_STORED},
    '{mk(ajb_pkg::FUNC_PACKET, 32'h7FFF_FFFF, 11'd20,   16'h0F0F), 1, ajb_pkg::ACT_TOOFAR},
    '{mk(ajb_pkg::FUNC_TICK,   32'd0,         11'd0,    16'h0000), 0, ajb_pkg::ACT_STORED}
  };

  // Receiver: random stall before each beat, one long hold-off on request
  initial begin
    int n;
    out_stall <= 1'b1;
    @(posedge clk);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 5);
      if (long_hold) begin
        n = 400;
        long_hold = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result checker
  always @(posedge clk) begin
    ajb_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (playout_q.size() == 0) report("unexpected beat", out_data.seq_out, 32'd0);
      else begin
        want = playout_q[0];
        playout_q.delete(0);
        if (out_data.action !== want.action)
          report("action", 32'(out_data.action), 32'(want.action));
        if (out_data.play_flag !== want.play_flag)
          report("play_flag", 32'(out_data.play_flag), 32'(want.play_flag));
        if (out_data.seq_out !== want.seq_out) report("seq_out", out_data.seq_out, want.seq_out);
        if (out_data.handle_out !== want.handle_out)
          report("handle_out", 32'(out_data.handle_out), 32'(want.handle_out));
        if (out_data.length_out !== want.length_out)
          report("length_out", 32'(out_data.length_out), 32'(want.length_out));
        if (out_data.last !== want.last)
          report("last", 32'(out_data.last), 32'(want.last));
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Main sequence
  initial begin
    bit counted;
    int done;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    maxb = 7'd8; minb = 7'd2; tickms = 10'd20; tout = 16'd2000;
    foreach (slot_len[i]) begin
      slot_len[i] = '0;
      slot_hdl[i] = '0;
    end
    reset_window();
    live = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE) @(posedge clk);

    // directed table at reset settings
    foreach (dir_rows[i]) send(dir_rows[i].beat, dir_rows[i].chk, dir_rows[i].act);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_regs(7'd2, 7'd1, 10'd1, 16'd0);
        1: set_regs(7'd64, 7'd64, 10'd1000, 16'd65535);
        2: set_regs(7'd127, 7'd0, 10'd1023, 16'd100);
        3: set_regs(7'd0, 7'd127, 10'd0, 16'd5);
        4: set_regs(7'd8, 7'd2, 10'd20, 16'd2000);
        default: set_regs(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                          10'($urandom_range(0, 1023)), 16'($urandom));
      endcase
      quiet = (ph == 4);
      send(mk(ajb_pkg::FUNC_START, 32'd0, 11'd0, 16'd0));
      if (ph == 1) long_hold = 1;
      done = 0;
      while (done < 34) begin
        random_beat(counted);
        if (counted) done++;
      end
      // let everything come out before the next register setting
      drain();
    end

    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
